// ===== src/crpm_pkg.sv =====
// Shared types and constants for the contiguous ring pointer manager.
// No dependencies; used by crpm_step, contiguous_ring_pointer_manager and the testbench.
package crpm_pkg;

  localparam int MAX_SIZE_LOG2_DEF = 16;
  localparam int POS_WIDTH_DEF     = 32;

  localparam int          SIZE_LOG2_W     = 5;
  localparam logic [4:0]  SIZE_LOG2_RESET = 5'd16;
  localparam int          FIELD_W         = 16;

  typedef enum logic [1:0] {
    CMD_WR_ACQUIRE = 2'd0,
    CMD_WR_RELEASE = 2'd1,
    CMD_RD_ACQUIRE = 2'd2,
    CMD_RD_RELEASE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                 granted;
    logic [FIELD_W-1:0]   region_offset;
    logic [FIELD_W-1:0]   read_length;
    logic [FIELD_W-1:0]   write_space;
    logic [FIELD_W-1:0]   read_count;
  } res_t;

endpackage

// ===== src/crpm_step.sv =====
// Next-state and result logic for one ring command.
// Depends on crpm_pkg (cmd_t, res_t, field widths).
module crpm_step #(
  parameter int MAX_SIZE_LOG2 = crpm_pkg::MAX_SIZE_LOG2_DEF,
  parameter int POS_WIDTH     = crpm_pkg::POS_WIDTH_DEF
) (
  input  logic [crpm_pkg::SIZE_LOG2_W-1:0] size_log2,
  input  crpm_pkg::cmd_t                   cmd,
  input  logic [crpm_pkg::FIELD_W-1:0]     amount,
  input  logic [POS_WIDTH-1:0]             wpos,
  input  logic [POS_WIDTH-1:0]             rpos,
  input  logic [POS_WIDTH-1:0]             pad_start,
  input  logic [crpm_pkg::FIELD_W-1:0]     pad_len,
  input  logic [crpm_pkg::FIELD_W-1:0]     pend,
  output logic [POS_WIDTH-1:0]             wpos_next,
  output logic [POS_WIDTH-1:0]             rpos_next,
  output logic [POS_WIDTH-1:0]             pad_start_next,
  output logic [crpm_pkg::FIELD_W-1:0]     pad_len_next,
  output logic [crpm_pkg::FIELD_W-1:0]     pend_next,
  output crpm_pkg::res_t                   res
);
  import crpm_pkg::*;

  localparam int PW = POS_WIDTH;
  localparam logic [SIZE_LOG2_W-1:0] LG_MAX = SIZE_LOG2_W'(MAX_SIZE_LOG2);

  function automatic logic [PW-1:0] free_fn(input logic [PW-1:0] w, input logic [PW-1:0] r,
                                            input logic [PW-1:0] size);
    logic [PW-1:0] used;
    used = w - r;
    if (used >= size) return '0;
    return size - used - PW'(1);
  endfunction

  // Serial-number order: a precedes b when a - b has its top bit set.
  function automatic logic before_fn(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW-1:0] d;
    d = a - b;
    return d[PW-1];
  endfunction

  // Readable bytes, not counting a tail pad that has been fully published.
  function automatic logic [PW-1:0] readable_fn(input logic [PW-1:0] w, input logic [PW-1:0] r,
                                                input logic [PW-1:0] pst,
                                                input logic [FIELD_W-1:0] plen);
    logic [PW-1:0] plen_pw;
    plen_pw = PW'(plen);
    if (plen != '0 && r == pst && !before_fn(w, r + plen_pw))
      return (w - r) - plen_pw;
    if (plen != '0 && before_fn(r, pst) && !before_fn(w, pst + plen_pw))
      return (pst - r) + ((w - pst) - plen_pw);
    return w - r;
  endfunction

  function automatic logic [FIELD_W-1:0] sat16(input logic [PW-1:0] v);
    if (|v[PW-1:FIELD_W]) return '1;
    return v[FIELD_W-1:0];
  endfunction

  logic [SIZE_LOG2_W-1:0] lg_eff;
  logic [PW-1:0]          size_pw;
  logic [PW-1:0]          mask_pw;
  logic [PW-1:0]          amount_pw;
  logic [PW-1:0]          avail;
  logic [PW-1:0]          wr_off;
  logic [PW-1:0]          wr_linear;
  logic [PW-1:0]          pad_end;
  logic [PW-1:0]          r_eff;
  logic [PW-1:0]          data;
  logic [PW-1:0]          rd_off;
  logic [PW-1:0]          rd_linear;
  logic                   blocked;

  always_comb begin
    if (size_log2 == '0) begin
      lg_eff = SIZE_LOG2_W'(1);
    end else if (size_log2 > LG_MAX) begin
      lg_eff = LG_MAX;
    end else begin
      lg_eff = size_log2;
    end
  end

  assign size_pw   = PW'(1) << lg_eff;
  assign mask_pw   = size_pw - PW'(1);
  assign amount_pw = PW'(amount);
  assign avail     = free_fn(wpos, rpos, size_pw);
  assign wr_off    = wpos & mask_pw;
  assign wr_linear = size_pw - wr_off;
  assign pad_end   = rpos + PW'(pad_len);

  always_comb begin
    wpos_next      = wpos;
    rpos_next      = rpos;
    pad_start_next = pad_start;
    pad_len_next   = pad_len;
    pend_next      = pend;
    res            = '0;
    r_eff          = rpos;
    blocked        = 1'b0;
    data           = '0;
    rd_off         = '0;
    rd_linear      = '0;

    case (cmd)
      CMD_WR_ACQUIRE: begin
        if (amount_pw != '0 && amount_pw < size_pw) begin
          pend_next = '0;
          if (amount_pw <= avail) begin
            if (amount_pw > wr_linear) begin
              // Wrap: the region starts at offset zero behind a tail pad.
              if (pad_len == '0 && ({1'b0, amount_pw} + {1'b0, wr_linear}) <= {1'b0, avail}) begin
                pend_next   = wr_linear[FIELD_W-1:0];
                res.granted = 1'b1;
              end
            end else begin
              res.granted       = 1'b1;
              res.region_offset = wr_off[FIELD_W-1:0];
            end
          end
        end
      end
      CMD_WR_RELEASE: begin
        if (pend != '0) begin
          pad_start_next = wpos;
          pad_len_next   = pend;
          wpos_next      = wpos + PW'(pend) + amount_pw;
          pend_next      = '0;
        end else begin
          wpos_next = wpos + amount_pw;
        end
        res.granted = 1'b1;
      end
      CMD_RD_ACQUIRE: begin
        if (pad_len != '0 && rpos == pad_start) begin
          if (before_fn(wpos, pad_end)) begin
            blocked = 1'b1;
          end else begin
            r_eff        = pad_end;
            rpos_next    = pad_end;
            pad_len_next = '0;
          end
        end
        if (!blocked) begin
          data = (pad_len != '0 && before_fn(r_eff, pad_start)) ? pad_start - r_eff
                                                                : wpos - r_eff;
          if (data != '0) begin
            rd_off            = r_eff & mask_pw;
            rd_linear         = size_pw - rd_off;
            res.granted       = 1'b1;
            res.region_offset = rd_off[FIELD_W-1:0];
            res.read_length   = sat16((data < rd_linear) ? data : rd_linear);
          end
        end
      end
      CMD_RD_RELEASE: begin
        rpos_next   = rpos + amount_pw;
        res.granted = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase

    res.write_space = sat16(free_fn(wpos_next, rpos_next, size_pw));
    res.read_count  = sat16(readable_fn(wpos_next, rpos_next, pad_start_next, pad_len_next));
  end

endmodule

// ===== src/contiguous_ring_pointer_manager.sv =====
// Top level of the contiguous ring pointer manager: input register, state, result register.
// Depends on crpm_pkg and crpm_step.
//
//   channel  signals                                  contents (low bits first)
//   s_axis   tvalid tready tdata[15:0] tuser[1:0]     tdata: amount; tuser: cmd
//   m_axis   tvalid tready tdata[63:0] tuser[0]       tdata: region_offset, read_length,
//                                                     write_space, read_count; tuser: granted
//   cfg      cfg_we cfg_wdata[4:0]                    ring_size_log2
//
// One command per cycle while the output is not stalled; a command is held in the input
// register and its result is then registered in the output register.
// The pointer update and the result are computed in the same cycle by crpm_step.
// Reset and a configuration write clear all positions; reset sets the size to 2^16.
// A stalled output holds its word; the input register keeps taking words while the
// output register is free or being drained.
module contiguous_ring_pointer_manager #(
  parameter int MAX_SIZE_LOG2 = crpm_pkg::MAX_SIZE_LOG2_DEF,
  parameter int POS_WIDTH     = crpm_pkg::POS_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [crpm_pkg::SIZE_LOG2_W-1:0] cfg_wdata,      // ring_size_log2
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,   // amount
  input  logic [1:0]                       s_axis_tuser,   // cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [63:0]                      m_axis_tdata,   // region_offset, read_length,
                                                           // write_space, read_count
  output logic                             m_axis_tuser    // granted
);
  import crpm_pkg::*;

  logic [SIZE_LOG2_W-1:0] size_log2;
  logic [POS_WIDTH-1:0]   wpos, rpos, pad_start;
  logic [FIELD_W-1:0]     pad_len, pend;
  logic [POS_WIDTH-1:0]   wpos_next, rpos_next, pad_start_next;
  logic [FIELD_W-1:0]     pad_len_next, pend_next;

  logic                   in_valid;
  cmd_t                   in_cmd;
  logic [FIELD_W-1:0]     in_amount;
  res_t                   step_res;
  res_t                   out_res;
  logic                   out_valid;
  logic                   adv;
  logic                   step_en;

  assign adv           = !out_valid || m_axis_tready;
  assign step_en       = in_valid && adv;
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step_en) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd    <= cmd_t'(s_axis_tuser);
      in_amount <= s_axis_tdata;
    end
  end

  crpm_step #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
    .POS_WIDTH     (POS_WIDTH)
  ) u_step (
    .size_log2      (size_log2),
    .cmd            (in_cmd),
    .amount         (in_amount),
    .wpos           (wpos),
    .rpos           (rpos),
    .pad_start      (pad_start),
    .pad_len        (pad_len),
    .pend           (pend),
    .wpos_next      (wpos_next),
    .rpos_next      (rpos_next),
    .pad_start_next (pad_start_next),
    .pad_len_next   (pad_len_next),
    .pend_next      (pend_next),
    .res            (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= SIZE_LOG2_RESET;
      wpos      <= '0;
      rpos      <= '0;
      pad_start <= '0;
      pad_len   <= '0;
      pend      <= '0;
    end else if (cfg_we) begin
      size_log2 <= cfg_wdata;
      wpos      <= '0;
      rpos      <= '0;
      pad_start <= '0;
      pad_len   <= '0;
      pend      <= '0;
    end else if (step_en) begin
      wpos      <= wpos_next;
      rpos      <= rpos_next;
      pad_start <= pad_start_next;
      pad_len   <= pad_len_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.granted;
  assign m_axis_tdata  = {out_res.read_count, out_res.write_space,
                          out_res.read_length, out_res.region_offset};

  // A noted pad is always consumed by the write release that follows it.
  a_release_clears_pend: assert property (@(posedge clk) disable iff (rst)
    (step_en && in_cmd == CMD_WR_RELEASE) |=> (pend == '0))
    else $error("pending pad survived a write release");

  // A held input word is never dropped before it has been processed.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step_en) |=> in_valid)
    else $error("input word lost while output was stalled");

  // Every processed word produces a result word on the next edge.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step_en |=> m_axis_tvalid)
    else $error("processed word produced no result");

  // A configuration write empties the ring.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (wpos == '0 && rpos == '0 && pad_len == '0 && pend == '0))
    else $error("configuration write did not clear the ring state");

endmodule

// ===== tb/sv/tb_contiguous_ring_pointer_manager.sv =====
// Self-checking testbench for contiguous_ring_pointer_manager: drives ring commands and
// checks every status word against a pointer-level prediction of the ring.
// Depends on crpm_pkg and the contiguous_ring_pointer_manager RTL.
module tb_contiguous_ring_pointer_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import crpm_pkg::*;

  // Ring pointer state as the block keeps it.
  typedef struct packed {
    logic [4:0]  size_log2;
    logic [31:0] wr_pos;
    logic [31:0] rd_pos;
    logic [31:0] pad_start;
    logic [15:0] pad_len;
    logic [15:0] pend_pad;
  } ring_t;

  typedef struct packed {
    cmd_t        op;
    logic [15:0] amt;
  } ring_word_t;

  localparam int PHASES = 12;
  localparam logic [4:0] PHASE_LOG2 [PHASES] = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd3,
                                                 5'd16, 5'd2, 5'd8, 5'd5, 5'd12, 5'd6};

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // amount
  logic [1:0]  s_axis_tuser = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // region_offset, read_length, write_space, read_count
  logic        m_axis_tuser;        // granted

  ring_t      ring_model;           // follows accepted words
  ring_t      ring_plan;            // follows queued words, steers the stimulus
  res_t       plan_res;
  res_t       model_res;
  res_t       want;
  ring_word_t next_word;
  ring_word_t cmd_backlog_q[$];
  res_t       expected_status_q[$];

  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          word_taken = 1'b0;
  bit          hold_request = 1'b0;
  bit          sender_gaps = 1'b0;
  bit          receiver_gaps = 1'b0;

  contiguous_ring_pointer_manager dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] ring_bytes(logic [4:0] lg);
    logic [4:0] clamped;
    clamped = lg;
    if (clamped < 5'd1) clamped = 5'd1;
    if (clamped > 5'd16) clamped = 5'd16;
    return 64'd1 << clamped;
  endfunction

  function automatic ring_t fresh_ring(logic [4:0] lg);
    ring_t st;
    st = '0;
    st.size_log2 = lg;
    return st;
  endfunction

  // Positions are serial numbers: distance taken mod 2^32.
  function automatic logic [63:0] pos_dist(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return {32'd0, d};
  endfunction

  function automatic bit is_behind(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic [15:0] clip16(logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [63:0] free_bytes(ring_t st);
    logic [63:0] size;
    logic [63:0] used;
    size = ring_bytes(st.size_log2);
    used = pos_dist(st.wr_pos, st.rd_pos);
    return (used >= size) ? 64'd0 : size - used - 1;
  endfunction

  // Readable bytes, leaving out a published tail pad that lies ahead of the reader.
  function automatic logic [63:0] readable_bytes(ring_t st);
    logic [31:0] pad_end_rd;
    logic [31:0] pad_end;
    pad_end_rd = st.rd_pos + st.pad_len;
    pad_end = st.pad_start + st.pad_len;
    if (st.pad_len != 0 && st.rd_pos == st.pad_start && !is_behind(st.wr_pos, pad_end_rd))
      return pos_dist(st.wr_pos, st.rd_pos) - st.pad_len;
    if (st.pad_len != 0 && is_behind(st.rd_pos, st.pad_start) && !is_behind(st.wr_pos, pad_end))
      return pos_dist(st.pad_start, st.rd_pos) +
             (pos_dist(st.wr_pos, st.pad_start) - st.pad_len);
    return pos_dist(st.wr_pos, st.rd_pos);
  endfunction

  task automatic apply_ring_cmd(inout ring_t st, input cmd_t op, input logic [15:0] amt,
                                output res_t res);
    logic [63:0] size;
    logic [63:0] mask;
    logic [63:0] avail;
    logic [63:0] pos;
    logic [63:0] linear;
    logic [63:0] data;
    logic [31:0] r;
    logic [31:0] nxt;
    logic [15:0] plen;
    logic [31:0] pst;
    bit          blocked;
    size = ring_bytes(st.size_log2);
    mask = size - 1;
    res = '0;
    case (op)
      CMD_WR_ACQUIRE: begin
        if (amt != 0 && amt < size) begin
          avail = free_bytes(st);
          st.pend_pad = '0;
          if (amt <= avail) begin
            pos = {32'd0, st.wr_pos} & mask;
            linear = size - pos;
            if (amt > linear) begin
              // Needs a tail pad; only one pad may be published at a time.
              if (st.pad_len == 0 && amt + linear <= avail) begin
                st.pend_pad = linear[15:0];
                res.granted = 1'b1;
              end
            end else begin
              res.granted = 1'b1;
              res.region_offset = pos[15:0];
            end
          end
        end
      end
      CMD_WR_RELEASE: begin
        if (st.pend_pad != 0) begin
          st.pad_start = st.wr_pos;
          st.pad_len = st.pend_pad;
          st.wr_pos = st.wr_pos + st.pend_pad + amt;
          st.pend_pad = '0;
        end else begin
          st.wr_pos = st.wr_pos + amt;
        end
        res.granted = 1'b1;
      end
      CMD_RD_ACQUIRE: begin
        r = st.rd_pos;
        plen = st.pad_len;
        pst = st.pad_start;
        blocked = 1'b0;
        if (plen != 0 && r == pst) begin
          nxt = r + plen;
          if (is_behind(st.wr_pos, nxt)) begin
            blocked = 1'b1;
          end else begin
            // The skip sticks even if no data follows the pad.
            r = nxt;
            st.rd_pos = r;
            st.pad_len = '0;
          end
        end
        if (!blocked) begin
          data = (plen != 0 && is_behind(r, pst)) ? pos_dist(pst, r) : pos_dist(st.wr_pos, r);
          if (data != 0) begin
            pos = {32'd0, r} & mask;
            linear = size - pos;
            res.granted = 1'b1;
            res.region_offset = pos[15:0];
            res.read_length = clip16((data < linear) ? data : linear);
          end
        end
      end
      default: begin
        st.rd_pos = st.rd_pos + amt;
        res.granted = 1'b1;
      end
    endcase
    res.write_space = clip16(free_bytes(st));
    res.read_count = clip16(readable_bytes(st));
  endtask

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] request_len(logic [63:0] sz);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 4) return 16'd0;
    if (p < 8) return (sz > 64'hFFFF) ? 16'hFFFF : 16'($urandom_range(32'(sz), 65535));
    if (p < 14) return 16'($urandom);
    if (p < 40) return 16'($urandom_range(1, 32'(sz - 1)));
    return 16'($urandom_range(1, 32'(sz / 4 + 1)));
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  task automatic queue_word(input cmd_t op, input logic [15:0] amt);
    ring_word_t w;
    w.op = op;
    w.amt = amt;
    apply_ring_cmd(ring_plan, op, amt, plan_res);
    cmd_backlog_q.push_back(w);
    words_queued++;
  endtask

  // Mostly well-formed acquire/release pairs, with abandoned grants, short releases
  // and a little noise mixed in.
  task automatic random_traffic(input int n);
    int          made;
    int unsigned pick;
    logic [63:0] sz;
    logic [15:0] amt;
    logic [15:0] rel;
    made = 0;
    while (made < n) begin
      sz = ring_bytes(ring_plan.size_log2);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        amt = request_len(sz);
        queue_word(CMD_WR_ACQUIRE, amt);
        made++;
        if (plan_res.granted && $urandom_range(0, 9) != 0) begin
          rel = ($urandom_range(0, 4) != 0) ? amt : 16'($urandom_range(0, amt));
          queue_word(CMD_WR_RELEASE, rel);
          made++;
        end
      end else if (pick < 90) begin
        queue_word(CMD_RD_ACQUIRE, 16'($urandom));
        made++;
        if (plan_res.granted) begin
          rel = ($urandom_range(0, 3) != 0) ? plan_res.read_length
                                            : 16'($urandom_range(1, plan_res.read_length));
          queue_word(CMD_RD_RELEASE, rel);
          made++;
        end
      end else begin
        if (pick < 95) queue_word(CMD_WR_ACQUIRE, 16'($urandom));
        else if (pick < 98) queue_word(CMD_RD_ACQUIRE, 16'($urandom));
        else if (pick < 99) queue_word(CMD_WR_RELEASE, 16'($urandom_range(0, 3)));
        else queue_word(CMD_RD_RELEASE, 16'($urandom_range(0, 3)));
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || expected_status_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only called with nothing in flight; the write also clears all positions.
  task automatic set_ring_size(input logic [4:0] lg);
    @(negedge clk);
    cfg_wdata = lg;
    cfg_we = 1'b1;
    ring_model = fresh_ring(lg);
    ring_plan = fresh_ring(lg);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sender: presents the next word once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog_q.size() != 0) begin
        next_word = cmd_backlog_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= next_word.amt;
        s_axis_tuser <= next_word.op;
        send_gap = sender_gaps ? idle_len() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 80;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (receiver_gaps && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // Output check first, then the accepted command is predicted and queued.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_status_q.size() == 0) begin
        $error("status word arrived with no command outstanding");
        fail_count++;
      end else begin
        want = expected_status_q.pop_front();
        check_field("granted", {15'd0, want.granted}, {15'd0, m_axis_tuser});
        check_field("region_offset", want.region_offset, m_axis_tdata[15:0]);
        check_field("read_length", want.read_length, m_axis_tdata[31:16]);
        check_field("write_space", want.write_space, m_axis_tdata[47:32]);
        check_field("read_count", want.read_count, m_axis_tdata[63:48]);
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      apply_ring_cmd(ring_model, cmd_t'(s_axis_tuser), s_axis_tdata, model_res);
      expected_status_q.push_back(model_res);
      words_accepted++;
      word_taken = 1'b1;
    end
  end

  initial begin
    ring_model = fresh_ring(SIZE_LOG2_RESET);
    ring_plan = fresh_ring(SIZE_LOG2_RESET);
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < PHASES; k++) begin
      if (k != 0) begin
        wait_drained();
        set_ring_size(PHASE_LOG2[k]);
      end
      sender_gaps = (k % 3 != 1) && (k != 2);
      receiver_gaps = (k % 4 != 2);
      if (k == 2) hold_request = 1'b1;

      if (k == 0) begin
        // Full-size ring: empty read, zero and largest requests, a one-byte tail pad,
        // a read release past the writer and the catch-up.
        queue_word(CMD_RD_ACQUIRE, 16'd0);
        queue_word(CMD_WR_ACQUIRE, 16'd0);
        queue_word(CMD_WR_ACQUIRE, 16'hFFFF);
        queue_word(CMD_WR_RELEASE, 16'hFFFF);
        queue_word(CMD_WR_ACQUIRE, 16'd1);
        queue_word(CMD_RD_ACQUIRE, 16'd0);
        queue_word(CMD_RD_RELEASE, 16'hFFFF);
        queue_word(CMD_WR_ACQUIRE, 16'd100);
        queue_word(CMD_WR_RELEASE, 16'd100);
        queue_word(CMD_RD_ACQUIRE, 16'd0);
        queue_word(CMD_RD_RELEASE, 16'hFFFF);
        queue_word(CMD_WR_RELEASE, 16'hFFFF);
      end else if (k == 1) begin
        // 16-byte ring: oversize request, a pad with no data behind it that the reader
        // skips, a pad skipped by a bare release, then a request that needs a second pad.
        queue_word(CMD_WR_ACQUIRE, 16'd16);
        queue_word(CMD_WR_ACQUIRE, 16'd10);
        queue_word(CMD_WR_RELEASE, 16'd10);
        queue_word(CMD_RD_ACQUIRE, 16'd0);
        queue_word(CMD_RD_RELEASE, 16'd10);
        queue_word(CMD_WR_ACQUIRE, 16'd8);
        queue_word(CMD_WR_RELEASE, 16'd0);
        queue_word(CMD_RD_ACQUIRE, 16'd0);
        queue_word(CMD_WR_ACQUIRE, 16'd12);
        queue_word(CMD_WR_RELEASE, 16'd12);
        queue_word(CMD_RD_ACQUIRE, 16'd0);
        queue_word(CMD_RD_RELEASE, 16'd12);
        queue_word(CMD_WR_ACQUIRE, 16'd6);
        queue_word(CMD_WR_RELEASE, 16'd6);
        queue_word(CMD_RD_RELEASE, 16'd10);
        queue_word(CMD_WR_ACQUIRE, 16'd12);
        queue_word(CMD_RD_ACQUIRE, 16'd0);
      end
      random_traffic(120);
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && expected_status_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/crpm_pkg.sv
src/crpm_step.sv
src/contiguous_ring_pointer_manager.sv
tb/sv/tb_contiguous_ring_pointer_manager.sv
